### rtl/core/pidis_pkg.sv
// ============================================================================
// pidis_pkg
// Shared types, constants and helpers for the PID controller with
// integral shaping.
// ============================================================================
`default_nettype none

package pidis_pkg;

  // Q16.16 angle constants, Q16.16 one and Q0.15 filter one
  localparam logic signed [33:0] PI_Q16     = 34'sd205887;
  localparam logic signed [33:0] TWO_PI_Q16 = 34'sd411775;
  localparam logic [16:0]        ONE_Q16    = 17'd65536;
  localparam logic [15:0]        ALPHA_ONE  = 16'd32768;

  // divider iterations (quotient bits)
  localparam int unsigned        DIV_STEPS  = 16;

  typedef enum logic [2:0] {
    CFG_KP         = 3'd0,
    CFG_KI_DT      = 3'd1,
    CFG_KD_OVER_DT = 3'd2,
    CFG_KF         = 3'd3,
    CFG_ILIM       = 3'd4,
    CFG_OLIM       = 3'd5,
    CFG_BANDS      = 3'd6,
    CFG_FMODE      = 3'd7
  } cfg_idx_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_ERR,
    ST_WRAP,
    ST_ABS,
    ST_DZ,
    ST_RSEL,
    ST_DIV,
    ST_ES_MUL,
    ST_ES_FIN,
    ST_MG_HI,
    ST_MG_LO,
    ST_MG_FIN,
    ST_MG_POST,
    ST_FLT_A,
    ST_FLT_B,
    ST_FLT_FIN,
    ST_FLT_RND,
    ST_SUM,
    ST_OUT
  } state_e;

  // which gain product the shared sequence is forming
  typedef enum logic [1:0] {
    OP_KI,
    OP_KD,
    OP_KP,
    OP_KF
  } op_e;

  typedef struct packed {
    logic        start;
    logic [23:0] rem0;
    logic [23:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [15:0] quot;
  } div_rsp_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic [32:0] abs32(input logic signed [31:0] v);
    logic signed [32:0] w;
    w = {v[31], v};
    return v[31] ? 33'(-w) : 33'(w);
  endfunction

endpackage

`default_nettype wire

### rtl/core/pidis_in_if.sv
// ============================================================================
// pidis_in_if
// Input channel: one beat carries target and measurement.
// ============================================================================
`default_nettype none

interface pidis_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] target;
  logic signed [31:0] measured;

  modport source (output valid, output target, output measured, input ready);
  modport sink   (input valid, input target, input measured, output ready);
endinterface

`default_nettype wire

### rtl/core/pidis_out_if.sv
// ============================================================================
// pidis_out_if
// Result channel: one beat carries drive, integral term and limit flag.
// ============================================================================
`default_nettype none

interface pidis_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] drive;
  logic signed [31:0] integral_term;
  logic               limited;

  modport source (output valid, output drive, output integral_term, output limited,
                  input ready);
  modport sink   (input valid, input drive, input integral_term, input limited,
                  output ready);
endinterface

`default_nettype wire

### rtl/core/pidis_mul.sv
// ============================================================================
// pidis_mul
// Shared unsigned 24x33 multiplier, product registered.
// ============================================================================
`default_nettype none

module pidis_mul (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [23:0] a_i,
  input  logic [32:0] b_i,
  output logic [56:0] prod_o
);

  logic [56:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= 57'(a_i) * 57'(b_i);
    end
  end

  assign prod_o = prod_q;

endmodule

`default_nettype wire

### rtl/core/pidis_div.sv
// ============================================================================
// pidis_div
// Restoring fraction divider: floor(rem0 * 2^16 / den), rem0 < den.
// One quotient bit per cycle.
// ============================================================================
`default_nettype none

module pidis_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pidis_pkg::div_req_t req_i,
  output pidis_pkg::div_rsp_t rsp_o
);

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [23:0] rem_q, rem_d;
  logic [23:0] den_q, den_d;
  logic [15:0] quot_q, quot_d;
  logic [24:0] trial;

  assign trial = {rem_q, 1'b0};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    quot_d = quot_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = req_i.rem0;
      den_d  = req_i.den;
      quot_d = '0;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d  = 24'(trial - {1'b0, den_q});
        quot_d = {quot_q[14:0], 1'b1};
      end else begin
        rem_d  = trial[23:0];
        quot_d = {quot_q[14:0], 1'b0};
      end
      cnt_d = cnt_q + 4'd1;
      if (cnt_q == 4'(pidis_pkg::DIV_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    den_q  <= den_d;
    quot_q <= quot_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

endmodule

`default_nettype wire

### rtl/core/pid_controller_with_integral_shaping.sv
// ============================================================================
// pid_controller_with_integral_shaping
// PID tick: dead zone, angle wrap, variable-speed integral with separation,
// filtered derivative, feedforward and output limiting.
// ============================================================================
// Sequencing: the speed ratio takes the 16-step divider only when the error
//   lies between bands A and B; the derivative filter adds its steps when
//   on. A new input beat is taken only once the result has been taken, as
//   the single shared multiplier and divider serve every step under the
//   sequencer.
// Reset: rst_ni (async, active low) clears configuration and control
//   registers, controller state and the output valid.
`default_nettype none

module pid_controller_with_integral_shaping (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i,
  pidis_in_if.sink    in_i,
  pidis_out_if.source out_o
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic signed [47:0] kp_q, ki_q, kd_q, kf_q;
  logic [30:0]        ilim_q, olim_q;
  logic [63:0]        bands_q;
  logic [16:0]        fmode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q    <= '0;
      ki_q    <= '0;
      kd_q    <= '0;
      kf_q    <= '0;
      ilim_q  <= '0;
      olim_q  <= '0;
      bands_q <= '0;
      fmode_q <= '0;
    end else if (cfg_we_i) begin
      unique case (pidis_pkg::cfg_idx_e'(cfg_idx_i))
        pidis_pkg::CFG_KP:         kp_q    <= cfg_data_i[47:0];
        pidis_pkg::CFG_KI_DT:      ki_q    <= cfg_data_i[47:0];
        pidis_pkg::CFG_KD_OVER_DT: kd_q    <= cfg_data_i[47:0];
        pidis_pkg::CFG_KF:         kf_q    <= cfg_data_i[47:0];
        pidis_pkg::CFG_ILIM:       ilim_q  <= cfg_data_i[30:0];
        pidis_pkg::CFG_OLIM:       olim_q  <= cfg_data_i[30:0];
        pidis_pkg::CFG_BANDS:      bands_q <= cfg_data_i;
        pidis_pkg::CFG_FMODE:      fmode_q <= cfg_data_i[16:0];
      endcase
    end
  end

  // Q8.8 bands promoted to Q16.16
  logic [23:0] dz, sep, ba, bb;
  logic [14:0] alpha;
  logic        on_meas, angle, filt_on;

  assign dz      = {bands_q[15:0], 8'h00};
  assign sep     = {bands_q[31:16], 8'h00};
  assign ba      = {bands_q[47:32], 8'h00};
  assign bb      = {bands_q[63:48], 8'h00};
  assign alpha   = fmode_q[14:0];
  assign on_meas = fmode_q[15];
  assign angle   = fmode_q[16];
  assign filt_on = !angle && (alpha != 15'd0);

  // --------------------------------------------------------------------------
  // Sequencer state and datapath registers
  // --------------------------------------------------------------------------
  pidis_pkg::state_e state_q, state_d;
  pidis_pkg::op_e    op_q;

  logic signed [31:0] tgt_q, meas_q, teff_q;
  logic signed [33:0] e_q;       // raw error, holds sat32 value after dead zone
  logic [33:0]        ae_q;      // |e| before dead-zone shift
  logic [16:0]        r_q;       // speed ratio Q1.16
  logic signed [32:0] es_q;      // error scaled by ratio
  logic signed [31:0] acc_q, iout_q, raw_q, d_q;
  logic signed [31:0] pe_q, pm_q, pt_q, pd_q, df_q;
  logic signed [63:0] sum_q, mres_q;
  logic [56:0]        hp_q;      // first partial product held
  logic signed [31:0] drive_q, iterm_q;
  logic               lim_q, ovalid_q;

  logic signed [31:0] e32;
  assign e32 = e_q[31:0];

  // shared units
  logic        mul_en;
  logic [23:0] mul_a;
  logic [32:0] mul_b;
  logic [56:0] prod;

  pidis_pkg::div_req_t div_req;
  pidis_pkg::div_rsp_t div_rsp;

  pidis_mul u_mul (
    .clk_i  (clk_i),
    .en_i   (mul_en),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  pidis_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // --------------------------------------------------------------------------
  // Gain product operand selection (magnitude form, sign applied after)
  // --------------------------------------------------------------------------
  logic signed [47:0] g_sel;
  logic signed [33:0] x_sel, x_neg;
  logic [47:0]        ug;
  logic [32:0]        ux;
  logic               mg_neg;

  always_comb begin
    unique case (op_q)
      pidis_pkg::OP_KI: begin
        g_sel = ki_q;
        x_sel = {es_q[32], es_q};
      end
      pidis_pkg::OP_KD: begin
        g_sel = kd_q;
        if (on_meas) begin
          x_sel = {{2{pm_q[31]}}, pm_q} - {{2{meas_q[31]}}, meas_q};
        end else begin
          x_sel = {{2{e32[31]}}, e32} - {{2{pe_q[31]}}, pe_q};
        end
      end
      pidis_pkg::OP_KP: begin
        g_sel = kp_q;
        x_sel = {{2{e32[31]}}, e32};
      end
      pidis_pkg::OP_KF: begin
        g_sel = kf_q;
        x_sel = {{2{teff_q[31]}}, teff_q} - {{2{pt_q[31]}}, pt_q};
      end
      default: begin
        g_sel = kp_q;
        x_sel = '0;
      end
    endcase
    x_neg  = -x_sel;
    ux     = x_sel[33] ? x_neg[32:0] : x_sel[32:0];
    ug     = g_sel[47] ? 48'(-g_sel) : 48'(g_sel);
    mg_neg = g_sel[47] ^ x_sel[33];
  end

  // --------------------------------------------------------------------------
  // Combinational helpers per step
  // --------------------------------------------------------------------------
  // dead zone
  logic signed [33:0] dz_s, e_dz;
  logic signed [31:0] e_dz_sat;
  assign dz_s = {10'b0, dz};

  always_comb begin
    e_dz = e_q;
    if (ae_q > 34'(dz)) begin
      e_dz = e_q[33] ? e_q + dz_s : e_q - dz_s;
    end
    e_dz_sat = pidis_pkg::sat32(64'(e_dz));
  end

  // integral clamp and angle-mode clear
  logic signed [31:0] ilim_s, olim_s, acc_c;
  logic               flip, satd;
  assign ilim_s = {1'b0, ilim_q};
  assign olim_s = {1'b0, olim_q};
  assign flip   = (pe_q > 0 && e32 < 0) || (pe_q < 0 && e32 > 0);
  assign satd   = (olim_q != 31'd0) && (pd_q >= olim_s || pd_q <= -olim_s);

  always_comb begin
    acc_c = acc_q;
    if (ilim_q != 31'd0) begin
      if (acc_q > ilim_s) begin
        acc_c = ilim_s;
      end else if (acc_q < -ilim_s) begin
        acc_c = -ilim_s;
      end
    end
    if (angle && (flip || satd)) begin
      acc_c = '0;
    end
  end

  // ratio select
  logic r_one, r_div;
  assign r_one = (ba == 24'd0 && bb == 24'd0) || (ae_q <= 34'(ba));
  assign r_div = ae_q < 34'(bb);

  // scaled error rounding
  logic [32:0]        es_mag;
  logic [56:0]        es_rnd;
  assign es_rnd = prod + 57'h8000;
  assign es_mag = 33'(es_rnd >> 16);

  // gain product completion
  logic [57:0]        lo_rnd, mg_mag;
  logic signed [63:0] mg_pos;
  assign lo_rnd = (58'(prod) + 58'h80_0000) >> 24;
  assign mg_mag = 58'(hp_q) + lo_rnd;
  assign mg_pos = $signed({6'b0, mg_mag});

  // integral update
  logic               sep_ok;
  logic signed [31:0] ki_term, acc_new;
  assign sep_ok  = (sep == 24'd0) || (ae_q < 34'(sep));
  assign ki_term = pidis_pkg::sat32(mres_q);
  assign acc_new = pidis_pkg::sat32(64'(acc_q) + 64'(ki_term));

  // derivative filter
  logic signed [63:0] flt_a, flt_b, flt_abs;
  logic [63:0]        flt_m;
  assign flt_a   = df_q[31]  ? -$signed({7'b0, hp_q}) : $signed({7'b0, hp_q});
  assign flt_b   = raw_q[31] ? -$signed({7'b0, prod}) : $signed({7'b0, prod});
  assign flt_abs = mres_q[63] ? -mres_q : mres_q;
  assign flt_m   = (64'(flt_abs) + 64'h4000) >> 15;

  // output clamp
  logic signed [63:0] olim_w, sum_c;
  logic               sum_lim;
  assign olim_w = {33'b0, olim_q};

  always_comb begin
    sum_c   = sum_q;
    sum_lim = 1'b0;
    if (olim_q != 31'd0) begin
      if (sum_q > olim_w) begin
        sum_c   = olim_w;
        sum_lim = 1'b1;
      end else if (sum_q < -olim_w) begin
        sum_c   = -olim_w;
        sum_lim = 1'b1;
      end
    end
  end

  logic signed [31:0] drive_new;
  assign drive_new = pidis_pkg::sat32(sum_c);

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pidis_pkg::ST_IDLE:    if (in_i.valid) state_d = pidis_pkg::ST_ERR;
      pidis_pkg::ST_ERR:     state_d = pidis_pkg::ST_WRAP;
      pidis_pkg::ST_WRAP:    state_d = pidis_pkg::ST_ABS;
      pidis_pkg::ST_ABS:     state_d = pidis_pkg::ST_DZ;
      pidis_pkg::ST_DZ:      state_d = pidis_pkg::ST_RSEL;
      pidis_pkg::ST_RSEL: begin
        if (!r_one && r_div) state_d = pidis_pkg::ST_DIV;
        else                 state_d = pidis_pkg::ST_ES_MUL;
      end
      pidis_pkg::ST_DIV:     if (div_rsp.done) state_d = pidis_pkg::ST_ES_MUL;
      pidis_pkg::ST_ES_MUL:  state_d = pidis_pkg::ST_ES_FIN;
      pidis_pkg::ST_ES_FIN:  state_d = pidis_pkg::ST_MG_HI;
      pidis_pkg::ST_MG_HI:   state_d = pidis_pkg::ST_MG_LO;
      pidis_pkg::ST_MG_LO:   state_d = pidis_pkg::ST_MG_FIN;
      pidis_pkg::ST_MG_FIN:  state_d = pidis_pkg::ST_MG_POST;
      pidis_pkg::ST_MG_POST: begin
        unique case (op_q)
          pidis_pkg::OP_KD: state_d = filt_on ? pidis_pkg::ST_FLT_A : pidis_pkg::ST_MG_HI;
          pidis_pkg::OP_KF: state_d = pidis_pkg::ST_SUM;
          default:          state_d = pidis_pkg::ST_MG_HI;
        endcase
      end
      pidis_pkg::ST_FLT_A:   state_d = pidis_pkg::ST_FLT_B;
      pidis_pkg::ST_FLT_B:   state_d = pidis_pkg::ST_FLT_FIN;
      pidis_pkg::ST_FLT_FIN: state_d = pidis_pkg::ST_FLT_RND;
      pidis_pkg::ST_FLT_RND: state_d = pidis_pkg::ST_MG_HI;
      pidis_pkg::ST_SUM:     state_d = pidis_pkg::ST_OUT;
      pidis_pkg::ST_OUT:     if (out_o.ready) state_d = pidis_pkg::ST_IDLE;
      default:               state_d = pidis_pkg::ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Shared unit controls
  // --------------------------------------------------------------------------
  always_comb begin
    mul_en       = 1'b0;
    mul_a        = '0;
    mul_b        = '0;
    div_req      = '0;
    unique case (state_q)
      pidis_pkg::ST_RSEL: begin
        div_req.start = !r_one && r_div;
        div_req.rem0  = 24'(bb - ae_q[23:0]);
        div_req.den   = 24'(bb - ba);
      end
      pidis_pkg::ST_ES_MUL: begin
        mul_en = 1'b1;
        mul_a  = 24'(r_q);
        mul_b  = pidis_pkg::abs32(e32);
      end
      pidis_pkg::ST_MG_HI: begin
        mul_en = 1'b1;
        mul_a  = ug[47:24];
        mul_b  = ux;
      end
      pidis_pkg::ST_MG_LO: begin
        mul_en = 1'b1;
        mul_a  = ug[23:0];
        mul_b  = ux;
      end
      pidis_pkg::ST_FLT_A: begin
        mul_en = 1'b1;
        mul_a  = 24'(alpha);
        mul_b  = pidis_pkg::abs32(df_q);
      end
      pidis_pkg::ST_FLT_B: begin
        mul_en = 1'b1;
        mul_a  = 24'(pidis_pkg::ALPHA_ONE - {1'b0, alpha});
        mul_b  = pidis_pkg::abs32(raw_q);
      end
      default: ;
    endcase
  end

  assign in_i.ready = (state_q == pidis_pkg::ST_IDLE);

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= pidis_pkg::ST_IDLE;
      op_q     <= pidis_pkg::OP_KI;
      ovalid_q <= 1'b0;
      acc_q    <= '0;
      pe_q     <= '0;
      pm_q     <= '0;
      pt_q     <= '0;
      pd_q     <= '0;
      df_q     <= '0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        pidis_pkg::ST_RSEL:   acc_q <= acc_c;
        pidis_pkg::ST_ES_FIN: op_q  <= pidis_pkg::OP_KI;
        pidis_pkg::ST_MG_POST: begin
          unique case (op_q)
            pidis_pkg::OP_KI: begin
              acc_q <= sep_ok ? acc_new : '0;
              op_q  <= pidis_pkg::OP_KD;
            end
            pidis_pkg::OP_KD: op_q <= pidis_pkg::OP_KP;
            pidis_pkg::OP_KP: op_q <= pidis_pkg::OP_KF;
            default: ;
          endcase
        end
        pidis_pkg::ST_FLT_RND: begin
          df_q <= flt_m[31:0] == 32'd0 ? 32'sd0
                : (mres_q[63] ? -$signed(flt_m[31:0]) : $signed(flt_m[31:0]));
        end
        pidis_pkg::ST_SUM: begin
          pm_q     <= meas_q;
          pt_q     <= teff_q;
          pe_q     <= e32;
          pd_q     <= drive_new;
          ovalid_q <= 1'b1;
        end
        pidis_pkg::ST_OUT: if (out_o.ready) ovalid_q <= 1'b0;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Payload registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      pidis_pkg::ST_IDLE: begin
        tgt_q  <= in_i.target;
        meas_q <= in_i.measured;
      end
      pidis_pkg::ST_ERR: begin
        e_q <= {{2{tgt_q[31]}}, tgt_q} - {{2{meas_q[31]}}, meas_q};
      end
      pidis_pkg::ST_WRAP: begin
        if (angle) begin
          if (e_q > pidis_pkg::PI_Q16) begin
            e_q <= e_q - pidis_pkg::TWO_PI_Q16;
          end else if (e_q < -pidis_pkg::PI_Q16) begin
            e_q <= e_q + pidis_pkg::TWO_PI_Q16;
          end
        end
      end
      pidis_pkg::ST_ABS: ae_q <= e_q[33] ? 34'(-e_q) : 34'(e_q);
      pidis_pkg::ST_DZ: begin
        if (ae_q < 34'(dz)) begin
          // inside dead zone: target snaps to measurement
          teff_q <= meas_q;
          e_q    <= '0;
          ae_q   <= '0;
        end else begin
          teff_q <= tgt_q;
          e_q    <= {{2{e_dz_sat[31]}}, e_dz_sat};
        end
      end
      pidis_pkg::ST_RSEL: r_q <= (r_one || !r_div) ? (r_one ? pidis_pkg::ONE_Q16 : 17'd0)
                                                    : r_q;
      pidis_pkg::ST_DIV:  if (div_rsp.done) r_q <= {1'b0, div_rsp.quot};
      pidis_pkg::ST_ES_FIN: begin
        es_q <= e32[31] ? -$signed(es_mag) : $signed(es_mag);
      end
      pidis_pkg::ST_MG_LO: hp_q <= prod;
      pidis_pkg::ST_MG_FIN: mres_q <= mg_neg ? -mg_pos : mg_pos;
      pidis_pkg::ST_MG_POST: begin
        unique case (op_q)
          pidis_pkg::OP_KI: iout_q <= sep_ok ? acc_new : '0;
          pidis_pkg::OP_KD: begin
            raw_q <= pidis_pkg::sat32(mres_q);
            d_q   <= pidis_pkg::sat32(mres_q);
          end
          pidis_pkg::OP_KP: sum_q <= mres_q + 64'(iout_q);
          pidis_pkg::OP_KF: sum_q <= sum_q + mres_q + 64'(d_q);
        endcase
      end
      pidis_pkg::ST_FLT_B:   hp_q   <= prod;
      pidis_pkg::ST_FLT_FIN: mres_q <= flt_a + flt_b;
      pidis_pkg::ST_FLT_RND: begin
        d_q <= mres_q[63] ? -$signed(flt_m[31:0]) : $signed(flt_m[31:0]);
      end
      pidis_pkg::ST_SUM: begin
        drive_q <= drive_new;
        iterm_q <= iout_q;
        lim_q   <= sum_lim;
      end
      default: ;
    endcase
  end

  assign out_o.valid         = ovalid_q;
  assign out_o.drive         = drive_q;
  assign out_o.integral_term = iterm_q;
  assign out_o.limited       = lim_q;

endmodule

`default_nettype wire

### test/tb_pid_controller_with_integral_shaping.sv
// ============================================================================
// tb_pid_controller_with_integral_shaping
// Self-checking bench for the PID tick: a behavioral predictor of the
// controller runs beside the block, one expected drive per input beat.
// Directed tests cover the field extremes, dead zone, speed bands, integral
// separation, angle mode, derivative options and back-pressure; random
// phases then sweep configurations and items, most with random idling.
// ============================================================================
`default_nettype none

module tb_pid_controller_with_integral_shaping;

  typedef struct {
    longint drive;
    longint iterm;
    logic   limited;
  } drive_t;

  logic clk_i;
  logic rst_ni;
  logic                  cfg_we;
  pidis_pkg::cfg_idx_e   cfg_idx;
  logic [63:0]           cfg_data;

  pidis_in_if  in_ch ();
  pidis_out_if out_ch ();

  pid_controller_with_integral_shaping u_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data),
    .in_i      (in_ch),
    .out_o     (out_ch)
  );

  // --------------------------------------------------------------------------
  // Controller model: registers and loop state as the block should hold them
  // --------------------------------------------------------------------------
  logic signed [47:0] m_kp, m_ki, m_kd, m_kf;
  logic [30:0] m_ilim, m_olim;
  logic [63:0] m_bands;
  logic [16:0] m_fmode;
  longint acc_q, perr_q, pmeas_q, ptgt_q, pdrive_q, dfilt_q;

  drive_t expected_drives[$];
  int     mismatches;

  bit  no_idle;     // phase flag: both sides run back to back
  int  rx_wait;     // cycles the receiver waits after a beat
  int  rx_hold;     // long hold-off for the back-pressure test

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // round(v / 2^s), half away from zero
  function automatic longint round_shift(longint v, int s);
    longint mg;
    mg = (v < 0) ? -v : v;
    mg = (mg + (longint'(1) <<< (s - 1))) >>> s;
    return (v < 0) ? -mg : mg;
  endfunction

  // Q24.24 gain times Q16.16 value, rounded back to Q16.16
  function automatic longint gain_mul(longint g, longint x);
    longint ug, ux, hi, lo, r;
    ug = (g < 0) ? -g : g;
    ux = (x < 0) ? -x : x;
    hi = ug >>> 24;
    lo = ug & 64'hFFFFFF;
    r  = hi * ux + ((lo * ux + 64'h800000) >>> 24);
    return ((g < 0) != (x < 0)) ? -r : r;
  endfunction

  // One controller tick: advances the model state and returns the drive
  function automatic drive_t pid_tick(logic signed [31:0] tgt_in, logic signed [31:0] meas_in);
    drive_t res;
    longint t, m, e, ae, dz, sep, ba, bb, alpha, lim_i, lim_o, r, es, i_out, raw, d, sum;
    bit angle, on_meas, flip, satd;
    t = tgt_in;
    m = meas_in;
    dz = m_bands[15:0];   dz  = dz <<< 8;
    sep = m_bands[31:16]; sep = sep <<< 8;
    ba = m_bands[47:32];  ba  = ba <<< 8;
    bb = m_bands[63:48];  bb  = bb <<< 8;
    alpha = m_fmode[14:0];
    on_meas = m_fmode[15];
    angle = m_fmode[16];
    lim_i = m_ilim;
    lim_o = m_olim;
    res.limited = 1'b0;

    // error, optional wrap into +-pi, dead zone
    e = t - m;
    if (angle) begin
      if (e > pidis_pkg::PI_Q16) e -= pidis_pkg::TWO_PI_Q16;
      else if (e < -pidis_pkg::PI_Q16) e += pidis_pkg::TWO_PI_Q16;
    end
    ae = (e < 0) ? -e : e;
    if (ae < dz) begin
      t = m;
      e = 0;
      ae = 0;
    end else if (ae > dz) begin
      e = (e > 0) ? e - dz : e + dz;
    end
    e = clip32(e);

    // speed ratio: full inside band A, ramps to zero at band B
    if ((ba == 0 && bb == 0) || ae <= ba) r = 65536;
    else if (ae < bb) r = ((bb - ae) <<< 16) / (bb - ba);
    else r = 0;

    if (lim_i != 0) begin
      if (acc_q > lim_i) acc_q = lim_i;
      else if (acc_q < -lim_i) acc_q = -lim_i;
    end
    if (angle) begin
      flip = (perr_q > 0 && e < 0) || (perr_q < 0 && e > 0);
      satd = (lim_o != 0) && (pdrive_q >= lim_o || pdrive_q <= -lim_o);
      if (flip || satd) acc_q = 0;
    end
    // separation: large error drops the integral altogether
    if (sep == 0 || ae < sep) begin
      es = round_shift(e * r, 16);
      acc_q = clip32(acc_q + clip32(gain_mul(m_ki, es)));
      i_out = acc_q;
    end else begin
      acc_q = 0;
      i_out = 0;
    end

    if (on_meas) raw = clip32(gain_mul(m_kd, pmeas_q - m));
    else raw = clip32(gain_mul(m_kd, e - perr_q));
    if (!angle && alpha != 0) begin
      d = round_shift(alpha * dfilt_q + (32768 - alpha) * raw, 15);
      dfilt_q = d;
    end else begin
      d = raw;
    end

    sum = gain_mul(m_kp, e) + i_out + d + gain_mul(m_kf, t - ptgt_q);
    if (lim_o != 0) begin
      if (sum > lim_o) begin
        sum = lim_o;
        res.limited = 1'b1;
      end else if (sum < -lim_o) begin
        sum = -lim_o;
        res.limited = 1'b1;
      end
    end
    sum = clip32(sum);

    pmeas_q = m;
    ptgt_q = t;
    perr_q = e;
    pdrive_q = sum;
    res.drive = sum;
    res.iterm = i_out;
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Clock and run limit
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #40_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Result side: ready with random gaps, checker on every accepted beat
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (rx_hold > 0) begin
        out_ch.ready <= 1'b0;
        rx_hold <= rx_hold - 1;
      end else if (rx_wait > 0) begin
        out_ch.ready <= 1'b0;
        rx_wait <= rx_wait - 1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic report_mismatch(string what, longint got, longint want);
    mismatches++;
    $display("mismatch %s: got %0d want %0d", what, got, want);
  endtask

  always @(posedge clk_i) begin
    drive_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      rx_wait <= no_idle ? 0 : $urandom_range(0, 7);
      if (expected_drives.size() == 0) begin
        report_mismatch("unexpected beat, drive", out_ch.drive, 0);
      end else begin
        want = expected_drives.pop_front();
        if (longint'(out_ch.drive) != want.drive)
          report_mismatch("drive", out_ch.drive, want.drive);
        if (longint'(out_ch.integral_term) != want.iterm)
          report_mismatch("integral_term", out_ch.integral_term, want.iterm);
        if (out_ch.limited !== want.limited)
          report_mismatch("limited", out_ch.limited, want.limited);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------
  // Sends one beat; the model runs at the edge that accepts it.
  task automatic send_tick(logic signed [31:0] tgt, logic signed [31:0] meas);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.target <= tgt;
    in_ch.measured <= meas;
    do @(posedge clk_i); while (!in_ch.ready);
    expected_drives.push_back(pid_tick(tgt, meas));
    @(negedge clk_i);
  endtask

  // Drops valid and waits until the block has nothing in flight.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (expected_drives.size() != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
  endtask

  task automatic cfg_write(pidis_pkg::cfg_idx_e idx, logic [63:0] v);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= v;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    @(negedge clk_i);
    case (idx)
      pidis_pkg::CFG_KP:         m_kp = v[47:0];
      pidis_pkg::CFG_KI_DT:      m_ki = v[47:0];
      pidis_pkg::CFG_KD_OVER_DT: m_kd = v[47:0];
      pidis_pkg::CFG_KF:         m_kf = v[47:0];
      pidis_pkg::CFG_ILIM:       m_ilim = v[30:0];
      pidis_pkg::CFG_OLIM:       m_olim = v[30:0];
      pidis_pkg::CFG_BANDS:      m_bands = v;
      default:                   m_fmode = v[16:0];
    endcase
  endtask

  task automatic cfg_all(logic [63:0] kp, ki, kd, kf, ilim, olim, bands, fmode);
    cfg_write(pidis_pkg::CFG_KP, kp);
    cfg_write(pidis_pkg::CFG_KI_DT, ki);
    cfg_write(pidis_pkg::CFG_KD_OVER_DT, kd);
    cfg_write(pidis_pkg::CFG_KF, kf);
    cfg_write(pidis_pkg::CFG_ILIM, ilim);
    cfg_write(pidis_pkg::CFG_OLIM, olim);
    cfg_write(pidis_pkg::CFG_BANDS, bands);
    cfg_write(pidis_pkg::CFG_FMODE, fmode);
  endtask

  localparam logic [63:0]        ONE_GAIN = 64'h1_000000;  // 1.0 in Q24.24
  localparam logic signed [31:0] ONE_Q = 32'sh10000;       // 1.0 in Q16.16

  // --------------------------------------------------------------------------
  // Directed tests
  // --------------------------------------------------------------------------
  // Field extremes, unlimited and then at the register extremes.
  task automatic test_extremes();
    cfg_all(ONE_GAIN, 0, 0, 0, 0, 0, 0, 0);
    send_tick(32'sh7FFFFFFF, 32'sh80000000);
    send_tick(32'sh80000000, 32'sh7FFFFFFF);
    send_tick(32'sh7FFFFFFF, 32'sh7FFFFFFF);
    send_tick(0, 0);
    send_tick(32'sh80000000, 32'sh80000000);
    wait_idle();
    // largest positive gains and limits, all bands at full scale
    cfg_all(64'hFFFF_7FFF_FFFF_FFFF, 64'h0000_7FFF_FFFF_FFFF, 64'h0000_7FFF_FFFF_FFFF,
            64'h0000_7FFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF,
            64'hFFFF_FFFF_FFFF_FFFF, 64'h1_FFFF);
    send_tick(32'sh7FFFFFFF, 32'sh80000000);
    send_tick(32'sh80000000, 32'sh7FFFFFFF);
    wait_idle();
    // most negative gains
    cfg_all(64'h0000_8000_0000_0000, 64'h0000_8000_0000_0000, 64'h0000_8000_0000_0000,
            64'h0000_8000_0000_0000, 0, 0, 0, 64'h0_7FFF);
    send_tick(32'sh7FFFFFFF, 32'sh80000000);
    send_tick(32'sh80000000, 32'sh7FFFFFFF);
    send_tick(32'sh12345678, -32'sh00ABCDEF);
    wait_idle();
  endtask

  // Dead zone of 1.0: below it the error vanishes, at it the error is kept.
  task automatic test_dead_zone();
    cfg_all(ONE_GAIN, ONE_GAIN >> 4, 0, ONE_GAIN, 0, 0, 64'h0100, 0);
    send_tick(32'sh8000, 0);
    send_tick(ONE_Q, 0);
    send_tick(-ONE_Q, 0);
    send_tick(3 * ONE_Q, 0);
    send_tick(-5 * ONE_Q, 32'sh1000);
    wait_idle();
  endtask

  // Band A 1.0, band B 4.0, separation at 8.0, integral limited to 3.0.
  task automatic test_integral_shaping();
    cfg_all(0, ONE_GAIN, 0, 0, 3 * ONE_Q, 0,
            {16'h0400, 16'h0100, 16'h0800, 16'h0000}, 0);
    send_tick(ONE_Q >> 1, 0);
    send_tick(ONE_Q, 0);
    send_tick(2 * ONE_Q + 32'sh1234, 0);
    send_tick(4 * ONE_Q, 0);
    send_tick(-3 * ONE_Q, 0);
    send_tick(9 * ONE_Q, 0);
    send_tick(ONE_Q, 0);
    wait_idle();
  endtask

  // Angle mode: wrap both ways, sign flips and a saturated previous drive.
  task automatic test_angle_mode();
    cfg_all(ONE_GAIN, ONE_GAIN >> 2, ONE_GAIN, 0, 0, 2 * ONE_Q, 0, 64'h1_4000);
    send_tick(32'sh30000, -32'sh30000);
    send_tick(-32'sh30000, 32'sh30000);
    send_tick(32'sh8000, 0);
    send_tick(-32'sh8000, 0);
    send_tick(32'sh40000, 0);
    send_tick(32'sh100, 0);
    wait_idle();
  endtask

  // Derivative on measurement with the low-pass on, then on error.
  task automatic test_derivative();
    cfg_all(0, 0, ONE_GAIN, 0, 0, 0, 0, 64'h0_C000);
    send_tick(0, ONE_Q);
    send_tick(0, -ONE_Q);
    send_tick(0, 4 * ONE_Q);
    wait_idle();
    cfg_write(pidis_pkg::CFG_FMODE, 64'h0_0000);
    send_tick(ONE_Q, 0);
    send_tick(-ONE_Q, 0);
    wait_idle();
  endtask

  // Receiver holds off while the sender keeps offering, so input stalls.
  task automatic test_backpressure();
    cfg_all(ONE_GAIN, ONE_GAIN >> 3, ONE_GAIN >> 1, ONE_GAIN >> 2, 0, 0, 0, 64'h0_2000);
    rx_hold = 400;
    for (int k = 0; k < 20; k++) send_tick($urandom_range(0, 65535) << 4, k << 12);
    wait_idle();
  endtask

  // --------------------------------------------------------------------------
  // Random phases
  // --------------------------------------------------------------------------
  function automatic logic [63:0] rand_gain();
    logic [63:0] hi_junk;
    longint g;
    hi_junk = {$urandom, 32'h0};
    case ($urandom_range(0, 4))
      0: g = $signed($urandom_range(0, 32'h1FFFFFF)) - 32'sh1000000;
      1: g = $signed($urandom_range(0, 32'h1FFFFFFF)) - 32'sh10000000;
      2: g = {$urandom, $urandom};
      3: g = $urandom_range(0, 32'h100000);
      default: g = 0;
    endcase
    return {hi_junk[63:48], g[47:0]};
  endfunction

  function automatic logic [63:0] rand_limit();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return {$urandom, $urandom};
      default: return $urandom_range(1, 32'h80000);
    endcase
  endfunction

  function automatic logic [63:0] rand_bands();
    logic [15:0] dz, sep, ba, bb;
    dz = ($urandom_range(0, 2) == 0) ? 16'($urandom) : 16'($urandom_range(0, 16'h40));
    sep = ($urandom_range(0, 1) == 0) ? 16'h0 : 16'($urandom_range(16'h100, 16'hFFFF));
    ba = 16'($urandom_range(0, 16'h400));
    bb = ba + 16'($urandom_range(0, 16'h800));
    if ($urandom_range(0, 3) == 0) {ba, bb} = 32'h0;
    if ($urandom_range(0, 7) == 0) {dz, sep, ba, bb} = {$urandom, $urandom};
    return {bb, ba, sep, dz};
  endfunction

  task automatic test_random_phases();
    logic signed [31:0] sp, tgt, meas;
    for (int ph = 0; ph < 11; ph++) begin
      no_idle = (ph % 4 == 3);
      cfg_all(rand_gain(), rand_gain(), rand_gain(), rand_gain(), rand_limit(),
              rand_limit(), rand_bands(), {$urandom, $urandom});
      sp = $signed($urandom_range(0, 32'h100000)) - 32'sh80000;
      for (int k = 0; k < 100; k++) begin
        case ($urandom_range(0, 9))
          0, 1: begin
            tgt = $urandom;
            meas = $urandom;
          end
          2, 3: begin
            // angle-scale values, both sides of the wrap
            tgt = $signed($urandom_range(0, 32'h80000)) - 32'sh40000;
            meas = $signed($urandom_range(0, 32'h80000)) - 32'sh40000;
          end
          default: begin
            // a loop tracking a slowly moving set point
            if ($urandom_range(0, 7) == 0)
              sp = $signed($urandom_range(0, 32'h100000)) - 32'sh80000;
            tgt = sp;
            meas = sp + $signed($urandom_range(0, 32'h60000)) - 32'sh30000;
          end
        endcase
        send_tick(tgt, meas);
      end
      wait_idle();
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = pidis_pkg::CFG_KP;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.target = '0;
    in_ch.measured = '0;
    out_ch.ready = 1'b0;
    {m_kp, m_ki, m_kd, m_kf} = '0;
    {m_ilim, m_olim, m_bands, m_fmode} = '0;
    {acc_q, perr_q, pmeas_q, ptgt_q, pdrive_q, dfilt_q} = '0;
    mismatches = 0;
    no_idle = 1'b0;
    rx_wait = 0;
    rx_hold = 0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_extremes();
    test_dead_zone();
    test_integral_shaping();
    test_angle_mode();
    test_derivative();
    test_backpressure();
    test_random_phases();

    wait_idle();
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
